FILE: rtl/cev_pkg.sv
// Shared types, widths and codes for the capsule envelope voxel classifier.
package cev_pkg;

	localparam int COORD_W    = 24;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int DOT_W      = SQ_W + 1;
	localparam int LABEL_W    = 16;
	localparam int EDGE_W     = 8;
	localparam int RSQ_W      = 49;
	localparam int RSQ_MAG_W  = RSQ_W - 1;
	localparam int MUL_W      = (SQ_W > RSQ_MAG_W) ? SQ_W : RSQ_MAG_W;
	localparam int MUL_LO_W   = (MUL_W + 1) / 2;
	localparam int MUL_HI_W   = MUL_W - MUL_LO_W;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int RHS_W      = PROD_W + 1;
	localparam int NUM_REGS   = 8;
	localparam int REG_LSB    = 3;
	localparam int APB_ADDR_W = $clog2(NUM_REGS) + REG_LSB;
	localparam int APB_DATA_W = 64;

	localparam logic [EDGE_W-1:0] EDGE_RESET = 8'd2;

	typedef enum logic [2:0] {
		REG_EDGE_LABEL,
		REG_HEAD_X,
		REG_HEAD_Y,
		REG_HEAD_Z,
		REG_TAIL_X,
		REG_TAIL_Y,
		REG_TAIL_Z,
		REG_RADIUS_SQ
	} reg_idx_t;

	typedef enum logic [2:0] {
		CAUSE_BG      = 3'd0,
		CAUSE_LABEL   = 3'd1,
		CAUSE_HEAD    = 3'd2,
		CAUSE_TAIL    = 3'd3,
		CAUSE_CYL     = 3'd4,
		CAUSE_OUTSIDE = 3'd5
	} cause_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	typedef struct packed {
		logic [LABEL_W-1:0]        body_label;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
	} in_word_t;

	typedef struct packed {
		logic       in_domain;
		logic [2:0] cause;
	} out_word_t;

	typedef struct packed {
		logic [EDGE_W-1:0]         edge_label;
		logic signed [COORD_W-1:0] head_x;
		logic signed [COORD_W-1:0] head_y;
		logic signed [COORD_W-1:0] head_z;
		logic signed [COORD_W-1:0] tail_x;
		logic signed [COORD_W-1:0] tail_y;
		logic signed [COORD_W-1:0] tail_z;
		logic [RSQ_W-1:0]          radius_sq;
	} cfg_t;

	// label decode: env set means the envelope tests decide
	typedef struct packed {
		logic   env;
		cause_t cause;
	} pre_t;

	typedef struct packed {
		logic [SQ_W-1:0]         hp2;
		logic [SQ_W-1:0]         tp2;
		logic [SQ_W-1:0]         d2;
		logic signed [DOT_W-1:0] dot;
		pre_t                    pre;
	} sums_t;

	// cyl_chk: cause still hangs on the final cross-term compare
	typedef struct packed {
		logic   cyl_chk;
		cause_t cause;
	} flags_t;

endpackage

FILE: rtl/cev_cfg.sv
// APB register file holding the bone geometry and envelope radius.
module cev_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [cev_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [cev_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [cev_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	output cev_pkg::cfg_t                       cfg
);

	localparam int ADDR_W  = cev_pkg::APB_ADDR_W;
	localparam int DATA_W  = cev_pkg::APB_DATA_W;
	localparam int REG_LSB = cev_pkg::REG_LSB;
	localparam int COORD_W = cev_pkg::COORD_W;
	localparam int EDGE_W  = cev_pkg::EDGE_W;
	localparam int RSQ_W   = cev_pkg::RSQ_W;

	cev_pkg::cfg_t     cfg_q;
	cev_pkg::reg_idx_t idx;
	logic              wr;

	assign idx    = cev_pkg::reg_idx_t'(paddr[ADDR_W-1:REG_LSB]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_label <= cev_pkg::EDGE_RESET;
			cfg_q.head_x     <= '0;
			cfg_q.head_y     <= '0;
			cfg_q.head_z     <= '0;
			cfg_q.tail_x     <= '0;
			cfg_q.tail_y     <= '0;
			cfg_q.tail_z     <= '0;
			cfg_q.radius_sq  <= '1;
		end else if (wr) begin
			case (idx)
				cev_pkg::REG_EDGE_LABEL: cfg_q.edge_label <= pwdata[EDGE_W-1:0];
				cev_pkg::REG_HEAD_X:     cfg_q.head_x     <= pwdata[COORD_W-1:0];
				cev_pkg::REG_HEAD_Y:     cfg_q.head_y     <= pwdata[COORD_W-1:0];
				cev_pkg::REG_HEAD_Z:     cfg_q.head_z     <= pwdata[COORD_W-1:0];
				cev_pkg::REG_TAIL_X:     cfg_q.tail_x     <= pwdata[COORD_W-1:0];
				cev_pkg::REG_TAIL_Y:     cfg_q.tail_y     <= pwdata[COORD_W-1:0];
				cev_pkg::REG_TAIL_Z:     cfg_q.tail_z     <= pwdata[COORD_W-1:0];
				cev_pkg::REG_RADIUS_SQ:  cfg_q.radius_sq  <= pwdata[RSQ_W-1:0];
				default: ;
			endcase
		end
	end

	// signed registers read back sign-extended
	always_comb begin
		case (idx)
			cev_pkg::REG_EDGE_LABEL: prdata = DATA_W'(cfg_q.edge_label);
			cev_pkg::REG_HEAD_X:     prdata = DATA_W'($signed(cfg_q.head_x));
			cev_pkg::REG_HEAD_Y:     prdata = DATA_W'($signed(cfg_q.head_y));
			cev_pkg::REG_HEAD_Z:     prdata = DATA_W'($signed(cfg_q.head_z));
			cev_pkg::REG_TAIL_X:     prdata = DATA_W'($signed(cfg_q.tail_x));
			cev_pkg::REG_TAIL_Y:     prdata = DATA_W'($signed(cfg_q.tail_y));
			cev_pkg::REG_TAIL_Z:     prdata = DATA_W'($signed(cfg_q.tail_z));
			cev_pkg::REG_RADIUS_SQ:  prdata = DATA_W'($signed(cfg_q.radius_sq));
			default:                 prdata = '0;
		endcase
	end

endmodule

FILE: rtl/cev_geom.sv
// Front pipeline: label decode, offsets, per-axis products and their sums.
module cev_geom (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vin,
	input  cev_pkg::in_word_t word,
	input  cev_pkg::cfg_t     cfg,
	output logic              valid_s3,
	output cev_pkg::sums_t    sums_s3
);

	localparam int DIFF_W  = cev_pkg::DIFF_W;
	localparam int SQ_W    = cev_pkg::SQ_W;
	localparam int DOT_W   = cev_pkg::DOT_W;
	localparam int LABEL_W = cev_pkg::LABEL_W;
	localparam int RSQ_W   = cev_pkg::RSQ_W;

	cev_pkg::coord_t pos  [3];
	cev_pkg::coord_t head [3];
	cev_pkg::coord_t tail [3];
	cev_pkg::pre_t   pre_in;

	logic                   v_s1, v_s2;
	cev_pkg::pre_t          pre_s1, pre_s2;
	cev_pkg::diff_t         hp_s1 [3];
	cev_pkg::diff_t         tp_s1 [3];
	cev_pkg::diff_t         d_s1  [3];
	logic signed [SQ_W-1:0] hpsq_s2 [3];
	logic signed [SQ_W-1:0] tpsq_s2 [3];
	logic signed [SQ_W-1:0] dsq_s2  [3];
	logic signed [SQ_W-1:0] dhp_s2  [3];

	always_comb begin
		pos[0]  = word.pos_x;  pos[1]  = word.pos_y;  pos[2]  = word.pos_z;
		head[0] = cfg.head_x;  head[1] = cfg.head_y;  head[2] = cfg.head_z;
		tail[0] = cfg.tail_x;  tail[1] = cfg.tail_y;  tail[2] = cfg.tail_z;
	end

	always_comb begin
		if (word.body_label == '0) begin
			pre_in = '{env: 1'b0, cause: cev_pkg::CAUSE_BG};
		end else if (word.body_label == LABEL_W'(cfg.edge_label)) begin
			pre_in = '{env: 1'b0, cause: cev_pkg::CAUSE_LABEL};
		end else if (cfg.radius_sq[RSQ_W-1]) begin
			pre_in = '{env: 1'b0, cause: cev_pkg::CAUSE_OUTSIDE};
		end else begin
			pre_in = '{env: 1'b1, cause: cev_pkg::CAUSE_OUTSIDE};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			v_s1     <= vin;
			v_s2     <= v_s1;
			valid_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_s1 <= pre_in;
			for (int k = 0; k < 3; k++) begin
				hp_s1[k] <= DIFF_W'(pos[k])  - DIFF_W'(head[k]);
				tp_s1[k] <= DIFF_W'(pos[k])  - DIFF_W'(tail[k]);
				d_s1[k]  <= DIFF_W'(tail[k]) - DIFF_W'(head[k]);
			end

			pre_s2 <= pre_s1;
			for (int k = 0; k < 3; k++) begin
				hpsq_s2[k] <= SQ_W'(hp_s1[k]) * SQ_W'(hp_s1[k]);
				tpsq_s2[k] <= SQ_W'(tp_s1[k]) * SQ_W'(tp_s1[k]);
				dsq_s2[k]  <= SQ_W'(d_s1[k])  * SQ_W'(d_s1[k]);
				dhp_s2[k]  <= SQ_W'(d_s1[k])  * SQ_W'(hp_s1[k]);
			end

			// squares are non-negative and their sum fits SQ_W unsigned
			sums_s3.hp2 <= unsigned'(hpsq_s2[0] + hpsq_s2[1] + hpsq_s2[2]);
			sums_s3.tp2 <= unsigned'(tpsq_s2[0] + tpsq_s2[1] + tpsq_s2[2]);
			sums_s3.d2  <= unsigned'(dsq_s2[0]  + dsq_s2[1]  + dsq_s2[2]);
			sums_s3.dot <= DOT_W'(dhp_s2[0]) + DOT_W'(dhp_s2[1]) + DOT_W'(dhp_s2[2]);
			sums_s3.pre <= pre_s2;
		end
	end

endmodule

FILE: rtl/cev_wmul.sv
// Three-stage unsigned multiplier built from four half-width partial products.
module cev_wmul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [cev_pkg::MUL_W-1:0]     a,
	input  logic [cev_pkg::MUL_W-1:0]     b,
	output logic [cev_pkg::PROD_W-1:0]    prod_s3
);

	localparam int MUL_W  = cev_pkg::MUL_W;
	localparam int LO_W   = cev_pkg::MUL_LO_W;
	localparam int HI_W   = cev_pkg::MUL_HI_W;
	localparam int LL_W   = 2 * LO_W;
	localparam int HH_W   = 2 * HI_W;
	localparam int MID_W  = MUL_W + 1;
	localparam int PROD_W = cev_pkg::PROD_W;

	logic [LL_W-1:0]  ll_s1, ll_s2;
	logic [HH_W-1:0]  hh_s1, hh_s2;
	logic [MUL_W-1:0] lh_s1, hl_s1;
	logic [MID_W-1:0] mid_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= LL_W'(a[LO_W-1:0]) * LL_W'(b[LO_W-1:0]);
			lh_s1 <= MUL_W'(a[LO_W-1:0]) * MUL_W'(b[MUL_W-1:LO_W]);
			hl_s1 <= MUL_W'(a[MUL_W-1:LO_W]) * MUL_W'(b[LO_W-1:0]);
			hh_s1 <= HH_W'(a[MUL_W-1:LO_W]) * HH_W'(b[MUL_W-1:LO_W]);

			mid_s2 <= MID_W'(lh_s1) + MID_W'(hl_s1);
			ll_s2  <= ll_s1;
			hh_s2  <= hh_s1;

			prod_s3 <= {hh_s2, ll_s2} + (PROD_W'(mid_s2) << LO_W);
		end
	end

endmodule

FILE: rtl/capsule_envelope_voxel_classifier.sv
// Top level: capsule envelope voxel classifier with APB setup and output skid.
//
// Usage
//   Voxel words enter on voxel/voxel_valid, taken at an edge with voxel_valid
//   high and voxel_stall low. Each word gives exactly one result word on
//   result/result_valid, in order, taken when result_stall is low.
//   Bone geometry, edge label and squared radius are set over the APB port
//   (64-bit data, register i at byte address 8*i) while no voxel is in flight.
// Timing
//   Throughput one word per cycle while voxel_stall is low. A result passes
//   through three front stages (offsets, per-axis products, sums), three
//   stages of the split wide multiplier for |hp|^2*|d|^2, r^2*|d|^2 and
//   (d.hp)^2, one stage for the right-hand sum, then the output register.
// Stall
//   The pipe advances as one while the skid slot is empty. When the output
//   is held, the next finished word parks in the skid slot and voxel_stall
//   rises for as long as that slot is full; nothing is dropped or repeated.
// Reset
//   arst_n clears all valid bits and loads the register reset values: edge
//   label 2, head and tail at the origin, radius_sq -1 (envelopes disabled).
module capsule_envelope_voxel_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cev_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [cev_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [cev_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              voxel_valid,
	output logic                              voxel_stall,
	input  cev_pkg::in_word_t                 voxel,
	output logic                              result_valid,
	input  logic                              result_stall,
	output cev_pkg::out_word_t                result
);

	localparam int SQ_W      = cev_pkg::SQ_W;
	localparam int DOT_W     = cev_pkg::DOT_W;
	localparam int MUL_W     = cev_pkg::MUL_W;
	localparam int PROD_W    = cev_pkg::PROD_W;
	localparam int RHS_W     = cev_pkg::RHS_W;
	localparam int RSQ_MAG_W = cev_pkg::RSQ_MAG_W;

	cev_pkg::cfg_t  cfg;
	cev_pkg::sums_t sums_s3;
	logic           v_s3;

	// whole pipe moves while the skid slot is free
	logic en;

	logic [RSQ_MAG_W-1:0] r2;
	logic [MUL_W-1:0]     hp2_m, d2_m, r2_m, dot_m;
	logic [PROD_W-1:0]    prod_hd, prod_rd, prod_dd;

	cev_pkg::flags_t flags_in;
	logic            v_s4, v_s5, v_s6, v_s7;
	cev_pkg::flags_t flags_s4, flags_s5, flags_s6, flags_s7;
	logic [PROD_W-1:0] lhs_s7;
	logic [RHS_W-1:0]  rhs_s7;

	cev_pkg::cause_t    fin_cause;
	cev_pkg::out_word_t fin_word;

	logic               out_v_q, skid_v_q;
	cev_pkg::out_word_t out_q, skid_q;

	assign en          = !skid_v_q;
	assign voxel_stall = skid_v_q;

	cev_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cev_geom u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (voxel_valid),
		.word     (voxel),
		.cfg      (cfg),
		.valid_s3 (v_s3),
		.sums_s3  (sums_s3)
	);

	// radius magnitude; sign bit is already folded into the label decode
	assign r2    = cfg.radius_sq[RSQ_MAG_W-1:0];
	assign hp2_m = MUL_W'(sums_s3.hp2);
	assign d2_m  = MUL_W'(sums_s3.d2);
	assign r2_m  = MUL_W'(r2);
	// only read when dot is non-negative, so the low bits are its magnitude
	assign dot_m = MUL_W'(sums_s3.dot[SQ_W-1:0]);

	cev_wmul u_mul_hd (.clk(clk), .en(en), .a(hp2_m), .b(d2_m), .prod_s3(prod_hd));
	cev_wmul u_mul_rd (.clk(clk), .en(en), .a(r2_m),  .b(d2_m), .prod_s3(prod_rd));
	cev_wmul u_mul_dd (.clk(clk), .en(en), .a(dot_m), .b(dot_m), .prod_s3(prod_dd));

	// sphere tests and the cylinder's axial range, in parallel with the multiplier
	always_comb begin
		if (!sums_s3.pre.env) begin
			flags_in = '{cyl_chk: 1'b0, cause: sums_s3.pre.cause};
		end else if (sums_s3.hp2 <= SQ_W'(r2)) begin
			flags_in = '{cyl_chk: 1'b0, cause: cev_pkg::CAUSE_HEAD};
		end else if (sums_s3.tp2 <= SQ_W'(r2)) begin
			flags_in = '{cyl_chk: 1'b0, cause: cev_pkg::CAUSE_TAIL};
		end else if (sums_s3.d2 != '0 && !sums_s3.dot[DOT_W-1]
				&& sums_s3.dot[SQ_W-1:0] <= sums_s3.d2) begin
			flags_in = '{cyl_chk: 1'b1, cause: cev_pkg::CAUSE_OUTSIDE};
		end else begin
			flags_in = '{cyl_chk: 1'b0, cause: cev_pkg::CAUSE_OUTSIDE};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flags_s4 <= flags_in;
			flags_s5 <= flags_s4;
			flags_s6 <= flags_s5;
			flags_s7 <= flags_s6;
			lhs_s7   <= prod_hd;
			rhs_s7   <= RHS_W'(prod_rd) + RHS_W'(prod_dd);
		end
	end

	// perpendicular distance test: |hp|^2|d|^2 <= r^2|d|^2 + (d.hp)^2
	always_comb begin
		if (flags_s7.cyl_chk) begin
			fin_cause = (RHS_W'(lhs_s7) <= rhs_s7) ? cev_pkg::CAUSE_CYL
			                                         : cev_pkg::CAUSE_OUTSIDE;
		end else begin
			fin_cause = flags_s7.cause;
		end
		fin_word.cause     = fin_cause;
		fin_word.in_domain = (fin_cause == cev_pkg::CAUSE_LABEL)
		                  || (fin_cause == cev_pkg::CAUSE_HEAD)
		                  || (fin_cause == cev_pkg::CAUSE_TAIL)
		                  || (fin_cause == cev_pkg::CAUSE_CYL);
	end

	// output register plus one skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (!out_v_q || !result_stall) begin
				out_v_q <= v_s7;
			end else begin
				skid_v_q <= v_s7;
			end
		end else if (!result_stall) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!out_v_q || !result_stall) begin
				out_q <= fin_word;
			end else begin
				skid_q <= fin_word;
			end
		end else if (!result_stall) begin
			out_q <= skid_q;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid slot full while output register empty");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !result_stall) |=> !skid_v_q)
		else $error("skid slot not drained after output taken");

	a_park_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && result_stall && !skid_v_q && v_s7) |=> skid_v_q)
		else $error("finished word not parked while output held");

	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && !skid_v_q && (!out_v_q || !result_stall)) |=> out_v_q)
		else $error("finished word did not reach output register");

endmodule

FILE: bench/voxel_verdict_checker.sv
// Checker for the voxel classifier: shadows the registers, predicts every verdict, compares.
`timescale 1ns / 1ps
module voxel_verdict_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cev_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [cev_pkg::APB_DATA_W-1:0] pwdata,
	input  logic                           pready,
	input  logic                           voxel_valid,
	input  logic                           voxel_stall,
	input  cev_pkg::in_word_t              voxel,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  cev_pkg::out_word_t             result,
	output int                             mismatches,
	output int                             outstanding
);
	import cev_pkg::*;

	cfg_t      shadow;
	out_word_t pending_verdicts[$];
	int        fail_tally;
	int        results_seen;

	function automatic longint sx(input logic [COORD_W-1:0] v);
		return longint'($signed(v));
	endfunction

	function automatic logic [63:0] norm_sq(input longint a, input longint b,
			input longint c);
		return 64'(a * a + b * b + c * c);
	endfunction

	// exact capsule test, every bound inclusive
	function automatic out_word_t classify_voxel(input in_word_t v, input cfg_t c);
		longint      hp[3];
		longint      tp[3];
		longint      dd[3];
		longint      dotv;
		logic [63:0] hp2, tp2, d2, r2, du;
		logic [127:0] lhs, rhs;
		cause_t      cz;
		out_word_t   o;
		hp[0] = sx(v.pos_x) - sx(c.head_x);
		hp[1] = sx(v.pos_y) - sx(c.head_y);
		hp[2] = sx(v.pos_z) - sx(c.head_z);
		tp[0] = sx(v.pos_x) - sx(c.tail_x);
		tp[1] = sx(v.pos_y) - sx(c.tail_y);
		tp[2] = sx(v.pos_z) - sx(c.tail_z);
		dd[0] = sx(c.tail_x) - sx(c.head_x);
		dd[1] = sx(c.tail_y) - sx(c.head_y);
		dd[2] = sx(c.tail_z) - sx(c.head_z);
		if (v.body_label == '0) begin
			cz = CAUSE_BG;
		end else if (v.body_label == {8'd0, c.edge_label}) begin
			cz = CAUSE_LABEL;
		end else if (c.radius_sq[RSQ_W-1]) begin
			cz = CAUSE_OUTSIDE;
		end else begin
			r2  = 64'(c.radius_sq);
			hp2 = norm_sq(hp[0], hp[1], hp[2]);
			tp2 = norm_sq(tp[0], tp[1], tp[2]);
			d2  = norm_sq(dd[0], dd[1], dd[2]);
			cz  = CAUSE_OUTSIDE;
			if (hp2 <= r2) begin
				cz = CAUSE_HEAD;
			end else if (tp2 <= r2) begin
				cz = CAUSE_TAIL;
			end else if (d2 != 0) begin
				dotv = dd[0] * hp[0] + dd[1] * hp[1] + dd[2] * hp[2];
				du   = 64'(dotv);
				if (dotv >= 0 && du <= d2) begin
					lhs = 128'(hp2) * 128'(d2);
					rhs = 128'(r2) * 128'(d2) + 128'(du) * 128'(du);
					if (lhs <= rhs)
						cz = CAUSE_CYL;
				end
			end
		end
		o.in_domain = (cz == CAUSE_LABEL || cz == CAUSE_HEAD ||
			cz == CAUSE_TAIL || cz == CAUSE_CYL);
		o.cause = cz;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			shadow.edge_label = EDGE_RESET;
			shadow.head_x     = '0;
			shadow.head_y     = '0;
			shadow.head_z     = '0;
			shadow.tail_x     = '0;
			shadow.tail_y     = '0;
			shadow.tail_z     = '0;
			shadow.radius_sq  = '1;
			pending_verdicts.delete();
			fail_tally   = 0;
			results_seen = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_ADDR_W-1:REG_LSB]))
					REG_EDGE_LABEL: shadow.edge_label = pwdata[EDGE_W-1:0];
					REG_HEAD_X:     shadow.head_x     = pwdata[COORD_W-1:0];
					REG_HEAD_Y:     shadow.head_y     = pwdata[COORD_W-1:0];
					REG_HEAD_Z:     shadow.head_z     = pwdata[COORD_W-1:0];
					REG_TAIL_X:     shadow.tail_x     = pwdata[COORD_W-1:0];
					REG_TAIL_Y:     shadow.tail_y     = pwdata[COORD_W-1:0];
					REG_TAIL_Z:     shadow.tail_z     = pwdata[COORD_W-1:0];
					REG_RADIUS_SQ:  shadow.radius_sq  = pwdata[RSQ_W-1:0];
					default: ;
				endcase
			end
			if (voxel_valid && !voxel_stall)
				pending_verdicts.push_back(classify_voxel(voxel, shadow));
			if (result_valid && !result_stall) begin
				if (pending_verdicts.size() == 0) begin
					if (fail_tally < 10)
						$display("result word %0d arrived with no voxel outstanding",
							results_seen);
					fail_tally++;
				end else begin
					want = pending_verdicts.pop_front();
					if (want.in_domain !== result.in_domain
							|| want.cause !== result.cause) begin
						if (fail_tally < 10)
							$display("word %0d in_domain/cause: expected %0d/%0d, got %0d/%0d",
								results_seen, want.in_domain, want.cause,
								result.in_domain, result.cause);
						fail_tally++;
					end
				end
				results_seen++;
			end
			mismatches  <= fail_tally;
			outstanding <= pending_verdicts.size();
		end
	end

endmodule

FILE: bench/capsule_envelope_voxel_classifier_tb.sv
// Top of the voxel classifier bench: clock, reset, APB setup, voxel stimulus and verdict.
`timescale 1ns / 1ps
module capsule_envelope_voxel_classifier_tb;
	import cev_pkg::*;

	localparam int     CYCLE_LIMIT = 400000;
	localparam longint C_MIN       = -(longint'(1) << 23);
	localparam longint C_MAX       = (longint'(1) << 23) - 1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  voxel_valid;
	logic                  voxel_stall;
	in_word_t              voxel;
	logic                  result_valid;
	logic                  result_stall;
	out_word_t             result;

	int mismatches;
	int outstanding;
	int cycles = 0;
	int words_sent = 0;
	int settings = 0;

	// calm: no idling on either side; hold_req: receiver does one long hold-off
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	// geometry of the current setting, used only to aim voxels at the capsule
	longint     gh[3];
	longint     gt[3];
	longint     reach;
	logic [7:0] cur_edge;

	capsule_envelope_voxel_classifier dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.voxel_valid  (voxel_valid),
		.voxel_stall  (voxel_stall),
		.voxel        (voxel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	voxel_verdict_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.voxel_valid  (voxel_valid),
		.voxel_stall  (voxel_stall),
		.voxel        (voxel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offer one voxel word after a random gap (none when calm) and hold it until taken.
	// Entered and left at a rising edge; valid is only lowered when a gap follows,
	// so back-to-back words keep valid high with a single assignment per edge.
	task automatic push_voxel(input in_word_t w);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			voxel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		voxel_valid <= 1'b1;
		voxel       <= w;
		@(posedge clk);
		while (voxel_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic vox(input int lbl, input longint x, input longint y, input longint z);
		in_word_t w;
		w.body_label = 16'(lbl);
		w.pos_x      = COORD_W'(x);
		w.pos_y      = COORD_W'(y);
		w.pos_z      = COORD_W'(z);
		push_voxel(w);
	endtask

	// Sender goes quiet until every predicted verdict has come back, then lets
	// the pipe settle well past its latency.
	task automatic drain();
		voxel_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// One APB write: setup then access. Bits above the register width carry
	// junk, which the block must drop. psel stays high for a following write;
	// the caller closes the transfer.
	task automatic wr_reg(input reg_idx_t idx, input logic [63:0] val);
		int          w;
		logic [63:0] mask;
		logic [63:0] junk;
		case (idx)
			REG_EDGE_LABEL: w = EDGE_W;
			REG_RADIUS_SQ:  w = RSQ_W;
			default:        w = COORD_W;
		endcase
		mask = (64'd1 << w) - 64'd1;
		junk = {$urandom(), $urandom()};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(int'(idx) << REG_LSB);
		pwdata  <= (val & mask) | (junk & ~mask);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
	endtask

	// New setting: always drained first, so registers only change while idle
	task automatic apply_cfg(input logic [7:0] e, input longint hx, input longint hy,
			input longint hz, input longint tx, input longint ty, input longint tz,
			input logic [RSQ_W-1:0] rsq, input longint span);
		drain();
		wr_reg(REG_EDGE_LABEL, 64'(e));
		wr_reg(REG_HEAD_X, 64'(hx));
		wr_reg(REG_HEAD_Y, 64'(hy));
		wr_reg(REG_HEAD_Z, 64'(hz));
		wr_reg(REG_TAIL_X, 64'(tx));
		wr_reg(REG_TAIL_Y, 64'(ty));
		wr_reg(REG_TAIL_Z, 64'(tz));
		wr_reg(REG_RADIUS_SQ, 64'(rsq));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		gh[0] = hx; gh[1] = hy; gh[2] = hz;
		gt[0] = tx; gt[1] = ty; gt[2] = tz;
		reach    = span;
		cur_edge = e;
		settings++;
	endtask

	// Mostly voxels scattered around the segment (a little past both ends,
	// within about one and a half radii), the rest raw noise over all bits.
	function automatic in_word_t next_voxel();
		in_word_t    w;
		logic [95:0] raw;
		longint      f;
		longint      q[3];
		int          pick;
		raw = {$urandom(), $urandom(), $urandom()};
		if ($urandom_range(0, 19) < 3)
			return raw[87:0];
		f = longint'($urandom_range(0, 320)) - 32;
		for (int k = 0; k < 3; k++)
			q[k] = gh[k] + ((gt[k] - gh[k]) * f) / 256
				+ longint'($urandom_range(0, 32'(2 * reach))) - reach;
		w.pos_x = COORD_W'(q[0]);
		w.pos_y = COORD_W'(q[1]);
		w.pos_z = COORD_W'(q[2]);
		pick = $urandom_range(0, 19);
		if (pick == 0)
			w.body_label = '0;
		else if (pick < 3)
			w.body_label = 16'(cur_edge);
		else if (pick == 3)
			w.body_label = 16'd1;
		else if (pick == 4)
			w.body_label = 16'($urandom_range(256, 65535));
		else
			w.body_label = 16'($urandom_range(2, 255));
		return w;
	endfunction

	// Random setting, then n words. Geometry: usual segment, head equal to
	// tail, or corners of the coordinate range. Radius: disabled, zero, the
	// largest, or a random square.
	task automatic random_phase(input int n, input bit quiet, input bit squeeze);
		int             k, gm, rm, rr;
		longint         hd[3];
		longint         tl[3];
		logic [RSQ_W-1:0] rsq;
		longint         span;
		k  = $urandom_range(4, 21);
		gm = $urandom_range(0, 9);
		for (int i = 0; i < 3; i++) begin
			hd[i] = longint'($urandom_range(0, 1 << 22)) - (longint'(1) << 21);
			if (gm == 0) begin
				tl[i] = hd[i];
			end else if (gm == 1) begin
				hd[i] = $urandom_range(0, 1) ? C_MAX : C_MIN;
				tl[i] = $urandom_range(0, 1) ? C_MAX : C_MIN;
			end else begin
				tl[i] = hd[i] + longint'($urandom_range(0, 2 << k)) - (longint'(1) << k);
			end
		end
		rm = $urandom_range(0, 9);
		case (rm)
			0: begin
				rsq  = {1'b1, 16'($urandom()), $urandom()};
				span = longint'(1) << k;
			end
			1: begin
				rsq  = '0;
				span = 4;
			end
			2: begin
				rsq  = {1'b0, {(RSQ_W-1){1'b1}}};
				span = longint'(1) << 23;
			end
			default: begin
				rr   = $urandom_range(0, 1 << k);
				rsq  = RSQ_W'(longint'(rr) * rr);
				span = rr + rr / 2 + 2;
			end
		endcase
		apply_cfg(8'($urandom_range(2, 255)), hd[0], hd[1], hd[2], tl[0], tl[1], tl[2],
			rsq, span);
		calm = quiet;
		if (squeeze)
			hold_req = 1'b1;
		repeat (n) push_voxel(next_voxel());
		calm = 1'b0;
	endtask

	// Receiver: a fresh random stall per result word (none when calm), plus one
	// long hold-off on request while the sender keeps pushing, so the skid slot
	// fills and the block has to stall its input.
	initial begin : receiver
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				gap = 400;
			end else begin
				gap = calm ? 0 : $urandom_range(0, 14);
			end
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			@(posedge clk);
			while (!result_valid) @(posedge clk);
		end
	end

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		voxel_valid  = 1'b0;
		voxel        = '0;
		result_stall = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: edge label 2, envelopes off. Background, label match,
		// everything else outside, including a label above 255 whose low byte is 2.
		vox(0, C_MIN, C_MIN, C_MIN);
		vox(2, C_MAX, C_MAX, C_MAX);
		vox(1, 0, 0, 0);
		vox(3, 100, -100, 5);
		vox(16'hFFFF, C_MAX, C_MIN, 0);
		vox(258, 0, 0, 0);

		// Segment along x, r = 100: head sphere and cylinder boundaries hit exactly,
		// one unit past them, inside the tail sphere, behind the head and beyond the tail.
		apply_cfg(8'd7, 0, 0, 0, 1000, 0, 0, 49'd10000, 200);
		vox(3, -100, 0, 0);
		vox(3, -101, 0, 0);
		vox(4, 1070, 70, 0);
		vox(5, 500, 100, 0);
		vox(5, 500, 101, 0);
		vox(16'h1234, 500, 0, -100);
		vox(6, 1150, 0, 0);
		vox(7, 0, 0, 0);

		// Head equal to tail: sphere only, no cylinder
		apply_cfg(8'd40, 1234, -567, 89, 1234, -567, 89, 49'd2500, 100);
		vox(3, 1284, -567, 89);
		vox(3, 1234, -516, 89);
		vox(40, 0, 0, 0);

		// Extremes: corner to corner, largest radius, edge label 255
		apply_cfg(8'd255, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
			{1'b0, {(RSQ_W-1){1'b1}}}, longint'(1) << 23);
		vox(255, 0, 0, 0);
		vox(256, C_MIN, C_MIN, C_MIN);
		vox(300, C_MAX, C_MAX, C_MAX);
		vox(9, 0, 0, 0);
		vox(1, C_MAX, C_MIN, 0);

		// Random settings; one with the long receiver hold-off, some calm
		for (int ph = 0; ph < 12; ph++)
			random_phase(115, (ph % 4 == 1) || (ph == 2), ph == 2);

		drain();
		$display("Sent %0d voxel words under %0d register settings.", words_sent, settings);
		$display("Covered label paths, exact sphere and cylinder bounds, a point segment, extreme coordinates and radii, random capsules and noise.");
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/cev_pkg.sv
rtl/cev_cfg.sv
rtl/cev_geom.sv
rtl/cev_wmul.sv
rtl/capsule_envelope_voxel_classifier.sv
bench/voxel_verdict_checker.sv
bench/capsule_envelope_voxel_classifier_tb.sv
